// File: src/b2brcg_pkg.sv
package b2brcg_pkg;

  localparam int unsigned REG_W   = 13;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned PRN_W   = 6;
  localparam int unsigned SHIFT_W = 14;

  localparam logic [POS_W-1:0] CODE_LEN     = POS_W'(10230);
  localparam logic [POS_W-1:0] LAST_POS     = POS_W'(10229);
  localparam logic [POS_W-1:0] G1_RELOAD_AT = POS_W'(8190);
  localparam logic [REG_W-1:0] REG_ONES     = '1;

  // Configuration register indexes.
  localparam logic REG_PRN   = 1'b0;
  localparam logic REG_SHIFT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  typedef struct packed {
    logic [REG_W-1:0] g1;
    logic [REG_W-1:0] g2;
    logic [POS_W-1:0] idx;
  } gen_state_t;

  // Initial phase word as listed: the MSB is stage 1.
  function automatic logic [REG_W-1:0] phase_word(input logic [PRN_W-1:0] prn);
    logic [REG_W-1:0] w;
    case (prn)
      6'd0, 6'd1: w = 13'h1025;
      6'd2:  w = 13'h1034;  6'd3:  w = 13'h10AD;  6'd4:  w = 13'h114F;
      6'd5:  w = 13'h1155;  6'd6:  w = 13'h11AE;  6'd7:  w = 13'h11EE;
      6'd8:  w = 13'h11FB;  6'd9:  w = 13'h1329;  6'd10: w = 13'h13DA;
      6'd11: w = 13'h1435;  6'd12: w = 13'h1444;  6'd13: w = 13'h1455;
      6'd14: w = 13'h145B;  6'd15: w = 13'h145C;  6'd16: w = 13'h14A3;
      6'd17: w = 13'h14F7;  6'd18: w = 13'h1501;  6'd19: w = 13'h153E;
      6'd20: w = 13'h15AB;  6'd21: w = 13'h15B1;  6'd22: w = 13'h1653;
      6'd23: w = 13'h1662;  6'd24: w = 13'h1698;  6'd25: w = 13'h16B6;
      6'd26: w = 13'h16F2;  6'd27: w = 13'h16FF;  6'd28: w = 13'h1712;
      6'd29: w = 13'h173C;  6'd30: w = 13'h17A1;  6'd31: w = 13'h17C8;
      6'd32: w = 13'h17D4;  6'd33: w = 13'h17EB;  6'd34: w = 13'h17F3;
      6'd35: w = 13'h1851;  6'd36: w = 13'h1894;  6'd37: w = 13'h18B7;
      6'd38: w = 13'h1911;  6'd39: w = 13'h1919;  6'd40: w = 13'h19AB;
      6'd41: w = 13'h19B1;  6'd42: w = 13'h19D2;  6'd43: w = 13'h1A55;
      6'd44: w = 13'h1A74;  6'd45: w = 13'h1ACB;  6'd46: w = 13'h1B57;
      6'd47: w = 13'h1C34;  6'd48: w = 13'h1C83;  6'd49: w = 13'h1C8B;
      6'd50: w = 13'h1CA3;  6'd51: w = 13'h1CA8;  6'd52: w = 13'h1D3B;
      6'd53: w = 13'h1D97;  6'd54: w = 13'h1E48;  6'd55: w = 13'h1E94;
      6'd56: w = 13'h1E99;  6'd57: w = 13'h1EDA;  6'd58: w = 13'h1EF8;
      6'd59: w = 13'h1EFF;  6'd60: w = 13'h1FB5;  6'd61: w = 13'h1FBD;
      6'd62: w = 13'h0B85;  6'd63: w = 13'h0B3B;
      default: w = 13'h1025;
    endcase
    return w;
  endfunction

  // Register word with bit k holding stage k+1.
  function automatic logic [REG_W-1:0] g2_phase(input logic [PRN_W-1:0] prn);
    logic [REG_W-1:0] w;
    logic [REG_W-1:0] r;
    w = phase_word(prn);
    for (int k = 0; k < REG_W; k++) begin
      r[k] = w[REG_W-1-k];
    end
    return r;
  endfunction

  function automatic gen_state_t advance(input gen_state_t s, input logic [PRN_W-1:0] prn);
    gen_state_t n;
    logic fb1;
    logic fb2;
    fb1 = s.g1[0] ^ s.g1[8] ^ s.g1[9] ^ s.g1[12];
    fb2 = s.g2[2] ^ s.g2[3] ^ s.g2[5] ^ s.g2[8] ^ s.g2[11] ^ s.g2[12];
    n.g1  = {s.g1[REG_W-2:0], fb1};
    n.g2  = {s.g2[REG_W-2:0], fb2};
    n.idx = s.idx + POS_W'(1);
    if (n.idx == G1_RELOAD_AT) begin
      n.g1 = REG_ONES;
    end
    if (n.idx >= CODE_LEN) begin
      n.idx = '0;
      n.g1  = REG_ONES;
      n.g2  = g2_phase(prn);
    end
    return n;
  endfunction

endpackage

// File: src/b2brcg_if.sv
interface b2brcg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface b2brcg_out_if;
  logic                            valid;
  logic                            ready;
  logic                            chip;
  logic [b2brcg_pkg::POS_W-1:0]    position;
  logic                            last_of_code;

  modport source (output valid, output chip, output position, output last_of_code,
                  input ready);
  modport sink   (input valid, input chip, input position, input last_of_code,
                  output ready);
endinterface

// File: src/b2b_ranging_code_generator.sv
// B2b ranging code generator. Each word on the input channel yields one code
// chip with its position, counted from the last restart, in the 10230-chip
// period; a word with restart low is taken every cycle while the result
// register drains, so chips stream at one per clock. A word with restart high
// sets G1 to all ones and G2 from the PRN register, then steps the shared G1/G2
// shift unit once per cycle to skip the programmed code phase offset (mod 10230)
// in chips; its chip appears once the walk ends and the result register is
// free, and no word is taken before then. Write the PRN and offset registers
// while the block is idle; they take effect at the next restart, except that
// the end-of-period G2 reload uses the prn register as it stands.
module b2b_ranging_code_generator (
  input  logic                 clk,
  input  logic                 rst_n,
  b2brcg_in_if.sink            in_if,
  b2brcg_out_if.source         out_if,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import b2brcg_pkg::*;

  logic [PRN_W-1:0]   prn_r;
  logic [SHIFT_W-1:0] shift_r;
  state_t             state_r, state_nxt;
  gen_state_t         gen_r, gen_nxt;
  gen_state_t         gen_adv;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   cnt_r, cnt_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic               ochip_r, ochip_nxt;
  logic [POS_W-1:0]   opos_r, opos_nxt;
  logic               olast_r, olast_nxt;
  logic               slot_free;
  logic               in_accept;
  logic               emit;
  logic               cfg_wr;
  logic [POS_W-1:0]   shift_mod;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign slot_free = !ovalid_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE) && slot_free;
  assign in_accept = in_if.valid && in_if.ready;

  assign out_if.valid        = ovalid_r;
  assign out_if.chip         = ochip_r;
  assign out_if.position     = opos_r;
  assign out_if.last_of_code = olast_r;

  assign shift_mod = (shift_r >= CODE_LEN) ? (shift_r - CODE_LEN) : shift_r;

  // The one G1/G2 step unit, used both by the skip walk and by each emitted chip.
  assign gen_adv = advance(gen_r, prn_r);

  always_comb begin
    case (paddr[2])
      REG_PRN:   prdata = {{(32-PRN_W){1'b0}}, prn_r};
      REG_SHIFT: prdata = {{(32-SHIFT_W){1'b0}}, shift_r};
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    gen_nxt    = gen_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && !out_if.ready;
    ochip_nxt  = ochip_r;
    opos_nxt   = opos_r;
    olast_nxt  = olast_r;
    emit       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_if.restart) begin
            gen_nxt.g1  = REG_ONES;
            gen_nxt.g2  = g2_phase(prn_r);
            gen_nxt.idx = '0;
            pos_nxt     = '0;
            cnt_nxt     = shift_mod;
            state_nxt   = ST_WALK;
          end else begin
            emit = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (cnt_r != '0) begin
          gen_nxt = gen_adv;
          cnt_nxt = cnt_r - POS_W'(1);
        end else if (slot_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // The chip of the current generator state goes out, then the generator steps.
    if (emit) begin
      ovalid_nxt = 1'b1;
      ochip_nxt  = gen_r.g1[REG_W-1] ^ gen_r.g2[REG_W-1];
      opos_nxt   = pos_r;
      olast_nxt  = (pos_r == LAST_POS);
      gen_nxt    = gen_adv;
      pos_nxt    = (pos_r == LAST_POS) ? '0 : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prn_r     <= PRN_W'(1);
      shift_r   <= '0;
      state_r   <= ST_IDLE;
      gen_r.g1  <= REG_ONES;
      gen_r.g2  <= g2_phase(PRN_W'(1));
      gen_r.idx <= '0;
      pos_r     <= '0;
      cnt_r     <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_PRN:   prn_r   <= pwdata[PRN_W-1:0];
          REG_SHIFT: shift_r <= pwdata[SHIFT_W-1:0];
          default:   ;
        endcase
      end
      state_r  <= state_nxt;
      gen_r    <= gen_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ochip_r <= ochip_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
  end

endmodule
